>>> rtl/sjf_pkg.sv
package sjf_pkg;

    // Default table depth.
    localparam int MaxJobsDef = 16;

    // Field widths of one input word and one result word.
    localparam int IdW   = 8;
    localparam int TimeW = 32;
    localparam int LenW  = 16;
    localparam int KindW = 3;

    // Result kinds.
    localparam logic [KindW-1:0] KIND_UNBLOCK = 3'd0;
    localparam logic [KindW-1:0] KIND_RAN     = 3'd1;
    localparam logic [KindW-1:0] KIND_IDLE    = 3'd2;
    localparam logic [KindW-1:0] KIND_ADD_OK  = 3'd3;
    localparam logic [KindW-1:0] KIND_ADD_REJ = 3'd4;

    // Input operations.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Sorted table commands.
    localparam logic [1:0] TBL_PEEK   = 2'd0;
    localparam logic [1:0] TBL_POP    = 2'd1;
    localparam logic [1:0] TBL_INSERT = 2'd2;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
    } t_tbl_cmd;

endpackage

>>> rtl/sjf_ram.sv
module sjf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sjf_table.sv
module sjf_table
    import sjf_pkg::*;
#(
    parameter int   Depth   = MaxJobsDef,
    parameter int   DataW   = 24,
    parameter int   KeyW    = 16,
    parameter logic AfterEq = 1'b0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tbl_cmd                   i_cmd,
    input  logic [DataW-1:0]           i_data,
    output logic                       o_busy,
    output logic [DataW-1:0]           o_head,
    output logic [$clog2(Depth+1)-1:0] o_count
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_PEEK = 3'd1;
    localparam logic [2:0] T_POP  = 3'd2;
    localparam logic [2:0] T_INS  = 3'd3;
    localparam logic [2:0] T_INS0 = 3'd4;

    logic [2:0]       r_st, n_st;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_idx, n_idx;
    logic [DataW-1:0] r_new, n_new;
    logic [DataW-1:0] r_head, n_head;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [DataW-1:0] wdata, rdata;
    logic             move;

    sjf_ram #(.Width(DataW), .Depth(Depth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // An entry moves up one place while its key is >= the new key (> when AfterEq).
    always_comb begin
        if (AfterEq) begin
            move = rdata[DataW-1 -: KeyW] > r_new[DataW-1 -: KeyW];
        end else begin
            move = rdata[DataW-1 -: KeyW] >= r_new[DataW-1 -: KeyW];
        end
    end

    // Walk sequencer: peek the head, shift down after a pop, shift up for an insert.
    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_new  = r_new;
        n_head = r_head;
        we     = 1'b0;
        waddr  = r_idx;
        wdata  = r_new;
        raddr  = r_idx;
        unique case (r_st)
            T_IDLE: begin
                if (i_cmd.go) begin
                    unique case (i_cmd.op)
                        TBL_PEEK: begin
                            raddr = '0;
                            n_st  = T_PEEK;
                        end
                        TBL_POP: begin
                            if (r_cnt > CW'(1)) begin
                                raddr = AW'(1);
                                n_idx = AW'(1);
                                n_st  = T_POP;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                            end
                        end
                        TBL_INSERT: begin
                            n_new = i_data;
                            if (r_cnt == '0) begin
                                we    = 1'b1;
                                waddr = '0;
                                wdata = i_data;
                                n_cnt = CW'(1);
                            end else begin
                                raddr = AW'(r_cnt - CW'(1));
                                n_idx = AW'(r_cnt - CW'(1));
                                n_st  = T_INS;
                            end
                        end
                        default: begin
                            n_st = T_IDLE;
                        end
                    endcase
                end
            end
            T_PEEK: begin
                n_head = rdata;
                n_st   = T_IDLE;
            end
            T_POP: begin
                we    = 1'b1;
                waddr = r_idx - AW'(1);
                wdata = rdata;
                if ((CW'(r_idx) + CW'(1)) < r_cnt) begin
                    raddr = r_idx + AW'(1);
                    n_idx = r_idx + AW'(1);
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    n_st  = T_IDLE;
                end
            end
            T_INS: begin
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                if (move) begin
                    wdata = rdata;
                    if (r_idx == '0) begin
                        n_st = T_INS0;
                    end else begin
                        raddr = r_idx - AW'(1);
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    wdata = r_new;
                    n_cnt = r_cnt + CW'(1);
                    n_st  = T_IDLE;
                end
            end
            T_INS0: begin
                we    = 1'b1;
                waddr = '0;
                wdata = r_new;
                n_cnt = r_cnt + CW'(1);
                n_st  = T_IDLE;
            end
            default: begin
                n_st = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= T_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
        r_idx  <= n_idx;
        r_new  <= n_new;
        r_head <= n_head;
    end

    assign o_busy  = (r_st != T_IDLE);
    assign o_head  = r_head;
    assign o_count = r_cnt;

endmodule

>>> rtl/shortest_job_first_dispatcher_unit.sv
// Shortest-job-first dispatcher.
// Input channel (i_valid / o_stall): one word is either an add (i_op = 0) carrying
// a job id, release time and run length, or a step (i_op = 1). Output channel
// (o_valid / i_stall): result words; o_last marks the final word of an input.
// An add yields one word; the sorted insert into the waiting table walks one
// memory entry per cycle from the tail. A step yields one unblock word per
// released job and then a ran or idle word. Each release is a head read, a
// shift-down pop of the waiting memory and a sorted insert into the ready
// memory, and the dispatch a head read and a pop of the ready memory. One word
// is in work at a time; o_stall is high from acceptance until the last result
// has been loaded into the output register and the ready table pop behind a
// ran word has finished. The output register holds its word while i_stall is
// high, and the sequencer waits at the next result until the register is free.
// Reset clears both table counts, the time and the control state; table
// memories need no clearing since entries are read only below their count.
module shortest_job_first_dispatcher_unit
    import sjf_pkg::*;
#(
    parameter int MaxJobs = MaxJobsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_op,
    input  logic [IdW-1:0]   i_job_id,
    input  logic [TimeW-1:0] i_release_time,
    input  logic [LenW-1:0]  i_run_length,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [KindW-1:0] o_kind,
    output logic [IdW-1:0]   o_out_job_id,
    output logic [TimeW-1:0] o_event_time,
    output logic [LenW-1:0]  o_ran_length,
    output logic             o_queues_empty,
    output logic             o_last
);

    localparam int CW = $clog2(MaxJobs + 1);
    localparam int WW = TimeW + LenW + IdW;
    localparam int RW = LenW + IdW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDW  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_PKW   = 4'd3;
    localparam logic [3:0] S_POPW  = 4'd4;
    localparam logic [3:0] S_POPWW = 4'd5;
    localparam logic [3:0] S_INSRW = 4'd6;
    localparam logic [3:0] S_DISP  = 4'd7;
    localparam logic [3:0] S_PKR   = 4'd8;
    localparam logic [3:0] S_POPR  = 4'd9;
    localparam logic [3:0] S_POPRW = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0]       r_st, n_st;
    logic [3:0]       r_after, n_after;
    logic [TimeW-1:0] r_time, n_time;

    // Pending result word.
    logic [KindW-1:0] r_p_kind, n_p_kind;
    logic [IdW-1:0]   r_p_id, n_p_id;
    logic [TimeW-1:0] r_p_time, n_p_time;
    logic [LenW-1:0]  r_p_len, n_p_len;
    logic             r_p_empty, n_p_empty;
    logic             r_p_last, n_p_last;

    // Output register.
    logic             r_ovalid, n_ovalid;
    logic [KindW-1:0] r_o_kind, n_o_kind;
    logic [IdW-1:0]   r_o_id, n_o_id;
    logic [TimeW-1:0] r_o_time, n_o_time;
    logic [LenW-1:0]  r_o_len, n_o_len;
    logic             r_o_empty, n_o_empty;
    logic             r_o_last, n_o_last;

    t_tbl_cmd         wcmd, rcmd;
    logic [WW-1:0]    wdata_in, whead;
    logic [RW-1:0]    rdata_in, rhead;
    logic             wbusy, rbusy;
    logic [CW-1:0]    wcnt, rcnt;
    logic             out_free;

    // Waiting table, keyed by release time, equal keys kept in arrival order.
    sjf_table #(.Depth(MaxJobs), .DataW(WW), .KeyW(TimeW), .AfterEq(1'b1)) u_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (wcmd),
        .i_data  (wdata_in),
        .o_busy  (wbusy),
        .o_head  (whead),
        .o_count (wcnt)
    );

    // Ready table, keyed by run length, a new job ahead of equal lengths.
    sjf_table #(.Depth(MaxJobs), .DataW(RW), .KeyW(LenW), .AfterEq(1'b0)) u_ready (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rcmd),
        .i_data  (rdata_in),
        .o_busy  (rbusy),
        .o_head  (rhead),
        .o_count (rcnt)
    );

    assign out_free = !r_ovalid || !i_stall;

    // Step and add sequencer.
    always_comb begin
        n_st      = r_st;
        n_after   = r_after;
        n_time    = r_time;
        n_p_kind  = r_p_kind;
        n_p_id    = r_p_id;
        n_p_time  = r_p_time;
        n_p_len   = r_p_len;
        n_p_empty = r_p_empty;
        n_p_last  = r_p_last;
        wcmd      = '{go: 1'b0, op: TBL_PEEK};
        rcmd      = '{go: 1'b0, op: TBL_PEEK};
        wdata_in  = {i_release_time, i_run_length, i_job_id};
        rdata_in  = whead[RW-1:0];
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_p_id   = i_job_id;
                    n_p_time = r_time;
                    n_p_len  = '0;
                    n_p_last = 1'b1;
                    if (i_op == OP_ADD) begin
                        if (wcnt == CW'(MaxJobs)) begin
                            n_p_kind  = KIND_ADD_REJ;
                            n_p_empty = 1'b0;
                            n_after   = S_IDLE;
                            n_st      = S_EMIT;
                        end else begin
                            wcmd = '{go: 1'b1, op: TBL_INSERT};
                            n_st = S_ADDW;
                        end
                    end else begin
                        n_st = S_CHK;
                    end
                end
            end
            S_ADDW: begin
                if (!wbusy) begin
                    n_p_kind  = KIND_ADD_OK;
                    n_p_empty = 1'b0;
                    n_after   = S_IDLE;
                    n_st      = S_EMIT;
                end
            end
            S_CHK: begin
                if (wcnt != '0 && rcnt != CW'(MaxJobs)) begin
                    wcmd = '{go: 1'b1, op: TBL_PEEK};
                    n_st = S_PKW;
                end else begin
                    n_st = S_DISP;
                end
            end
            S_PKW: begin
                if (!wbusy) begin
                    if (whead[WW-1 -: TimeW] <= r_time) begin
                        n_p_kind  = KIND_UNBLOCK;
                        n_p_id    = whead[IdW-1:0];
                        n_p_time  = r_time;
                        n_p_len   = '0;
                        n_p_empty = 1'b0;
                        n_p_last  = 1'b0;
                        n_after   = S_POPW;
                        n_st      = S_EMIT;
                    end else begin
                        n_st = S_DISP;
                    end
                end
            end
            S_POPW: begin
                wcmd = '{go: 1'b1, op: TBL_POP};
                n_st = S_POPWW;
            end
            S_POPWW: begin
                if (!wbusy) begin
                    rcmd = '{go: 1'b1, op: TBL_INSERT};
                    n_st = S_INSRW;
                end
            end
            S_INSRW: begin
                if (!rbusy) begin
                    n_st = S_CHK;
                end
            end
            S_DISP: begin
                if (rcnt != '0) begin
                    rcmd = '{go: 1'b1, op: TBL_PEEK};
                    n_st = S_PKR;
                end else begin
                    n_p_kind  = KIND_IDLE;
                    n_p_id    = '0;
                    n_p_time  = r_time;
                    n_p_len   = LenW'(1);
                    n_p_empty = (wcnt == '0);
                    n_p_last  = 1'b1;
                    n_time    = r_time + TimeW'(1);
                    n_after   = S_IDLE;
                    n_st      = S_EMIT;
                end
            end
            S_PKR: begin
                if (!rbusy) begin
                    n_p_kind  = KIND_RAN;
                    n_p_id    = rhead[IdW-1:0];
                    n_p_time  = r_time;
                    n_p_len   = rhead[RW-1 -: LenW];
                    n_p_empty = (wcnt == '0) && (rcnt == CW'(1));
                    n_p_last  = 1'b1;
                    n_time    = r_time + TimeW'(rhead[RW-1 -: LenW]);
                    n_after   = S_POPR;
                    n_st      = S_EMIT;
                end
            end
            S_POPR: begin
                rcmd = '{go: 1'b1, op: TBL_POP};
                n_st = S_POPRW;
            end
            S_POPRW: begin
                if (!rbusy) begin
                    n_st = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_st = r_after;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the pending word when free, cleared when taken.
    always_comb begin
        n_ovalid  = r_ovalid;
        n_o_kind  = r_o_kind;
        n_o_id    = r_o_id;
        n_o_time  = r_o_time;
        n_o_len   = r_o_len;
        n_o_empty = r_o_empty;
        n_o_last  = r_o_last;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        if (r_st == S_EMIT && out_free) begin
            n_ovalid  = 1'b1;
            n_o_kind  = r_p_kind;
            n_o_id    = r_p_id;
            n_o_time  = r_p_time;
            n_o_len   = r_p_len;
            n_o_empty = r_p_empty;
            n_o_last  = r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_after  <= S_IDLE;
            r_time   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_after  <= n_after;
            r_time   <= n_time;
            r_ovalid <= n_ovalid;
        end
        r_p_kind  <= n_p_kind;
        r_p_id    <= n_p_id;
        r_p_time  <= n_p_time;
        r_p_len   <= n_p_len;
        r_p_empty <= n_p_empty;
        r_p_last  <= n_p_last;
        r_o_kind  <= n_o_kind;
        r_o_id    <= n_o_id;
        r_o_time  <= n_o_time;
        r_o_len   <= n_o_len;
        r_o_empty <= n_o_empty;
        r_o_last  <= n_o_last;
    end

    assign o_stall        = (r_st != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_kind         = r_o_kind;
    assign o_out_job_id   = r_o_id;
    assign o_event_time   = r_o_time;
    assign o_ran_length   = r_o_len;
    assign o_queues_empty = r_o_empty;
    assign o_last         = r_o_last;

endmodule

>>> rtl/sjf_chk.sv
module sjf_chk
    import sjf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [KindW-1:0] o_kind,
    input logic [IdW-1:0]   o_out_job_id,
    input logic [TimeW-1:0] o_event_time,
    input logic [LenW-1:0]  o_ran_length,
    input logic             o_queues_empty,
    input logic             o_last
);

    // An idle word names no job and reports one tick.
    a_idle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_IDLE) |-> (o_out_job_id == '0 && o_ran_length == LenW'(1)
            && o_last))
        else $error("idle word malformed");

    // An unblock word is never the last word and the tables are not empty after it.
    a_unblock_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_UNBLOCK) |-> (!o_last && !o_queues_empty
            && o_ran_length == '0))
        else $error("unblock word malformed");

    // An accepted add leaves at least one job waiting.
    a_add_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ADD_OK) |-> (o_last && !o_queues_empty))
        else $error("add word malformed");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_out_job_id)
            && $stable(o_event_time)))
        else $error("stalled word changed");

endmodule

bind shortest_job_first_dispatcher_unit sjf_chk u_sjf_chk (.*);
